>>> rtl/pps_pkg.sv
// Shared types and codes for the preemptive priority scheduler.
package pps_pkg;

  // Event codes carried in the opcode field
  localparam logic OP_ARRIVAL  = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Command word, one per event
  typedef struct packed {
    logic        opcode;
    logic [31:0] timestamp;
    logic [7:0]  new_id;
    logic [31:0] new_arrival;
    logic [15:0] new_total_burst;
    logic [15:0] new_remaining_burst;
    logic [7:0]  new_priority;
  } sched_in_t;

  // Result word, one per event
  typedef struct packed {
    logic        idle;
    logic        dropped;
    logic        preempted;
    logic [7:0]  run_id;
    logic [31:0] run_arrival;
    logic [15:0] run_total_burst;
    logic [15:0] run_remaining_burst;
    logic [7:0]  run_priority;
    logic [31:0] run_start;
    logic [31:0] run_end;
  } sched_out_t;

  // One ready-queue entry
  typedef struct packed {
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] total;
    logic [31:0] arrival;
  } queue_entry_t;

  // What a queue cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_e;

endpackage

>>> rtl/pps_cell.sv
// One ready-queue cell: holds an entry, loads new data or takes a neighbor's entry.
module pps_cell (
  input  logic                  clk_i,
  input  pps_pkg::cell_op_e     op_i,
  input  pps_pkg::queue_entry_t load_i,
  input  pps_pkg::queue_entry_t prev_i,
  input  pps_pkg::queue_entry_t next_i,
  output pps_pkg::queue_entry_t entry_o
);
  import pps_pkg::*;

  queue_entry_t entry_q, entry_d;

  // Next entry: hold, insert, shift toward tail, or shift toward head
  always_comb begin
    case (op_i)
      CELL_HOLD:      entry_d = entry_q;
      CELL_LOAD:      entry_d = load_i;
      CELL_FROM_PREV: entry_d = prev_i;
      CELL_FROM_NEXT: entry_d = next_i;
      default:        entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/priority_preemptive_scheduler.sv
// Top level: preemptive priority scheduler with a ready queue built as a row of cells.
//
//  channel   signals                    direction  accepted when
//  command   start_i, busy_o, cmd_i     in         start_i high and busy_o low
//  result    done_o, res_o              out        every cycle done_o is high
//
// An arrival is resolved in the accept cycle; its result word shows in the next cycle.
// A completion scans the queue for the most urgent entry, one cell per cycle, then
// removes it: busy_o stays high over the scan and removal; result in the cycle after.
// A completion on an empty queue finishes like an arrival, without busy.
// Reset (rst_ni low, asynchronous) empties the queue and leaves no process running.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module priority_preemptive_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pps_pkg::sched_in_t  cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output pps_pkg::sched_out_t res_o
);
  import pps_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  typedef struct packed {
    queue_entry_t ent;
    logic [31:0]  start;
    logic [31:0]  fin;
  } run_t;

  // Control state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] scan_idx_q, scan_idx_d;
  logic          run_valid_q, run_valid_d;
  logic          done_q, done_d;

  // Payload state
  run_t          run_q, run_d;
  queue_entry_t  best_q, best_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [31:0]   ts_q, ts_d;
  sched_out_t    res_q, res_d;

  // Cell row
  queue_entry_t  cell_q  [QUEUE_DEPTH];
  queue_entry_t  cell_pv [QUEUE_DEPTH];
  queue_entry_t  cell_nx [QUEUE_DEPTH];
  cell_op_e      cell_op [QUEUE_DEPTH];
  queue_entry_t  ins_entry;

  logic accept, arrival, completion;
  logic full, do_drop, do_start, do_preempt, do_insert, comp_empty, apply;
  logic [QUEUE_DEPTH-1:0] gt, ahead;
  logic any_gt;
  queue_entry_t new_entry, old_entry, scan_entry;
  logic [31:0]  elapsed;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      // neighbor links, ends tied to own entry (never selected there)
      if (g == 0) begin : g_head
        assign cell_pv[g] = cell_q[g];
      end else begin : g_mid_p
        assign cell_pv[g] = cell_q[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign cell_nx[g] = cell_q[g];
      end else begin : g_mid_n
        assign cell_nx[g] = cell_q[g+1];
      end

      pps_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (cell_op[g]),
        .load_i  (ins_entry),
        .prev_i  (cell_pv[g]),
        .next_i  (cell_nx[g]),
        .entry_o (cell_q[g])
      );
    end
  endgenerate

  // Event decode
  assign accept     = start_i && (state_q == ST_IDLE);
  assign arrival    = accept && (cmd_i.opcode == OP_ARRIVAL);
  assign completion = accept && (cmd_i.opcode == OP_COMPLETE);
  assign full       = count_q >= CW'(QUEUE_DEPTH);
  assign do_drop    = arrival && full;
  assign do_start   = arrival && !full &&
                      (!run_valid_q || (cmd_i.new_priority < run_q.ent.prio));
  assign do_preempt = do_start && run_valid_q;
  assign do_insert  = arrival && !full && !do_start;
  assign comp_empty = completion && (count_q == '0);
  assign apply      = state_q == ST_APPLY;

  assign new_entry = '{pid:       cmd_i.new_id,
                       prio:      cmd_i.new_priority,
                       remaining: cmd_i.new_remaining_burst,
                       total:     cmd_i.new_total_burst,
                       arrival:   cmd_i.new_arrival};

  // Preempted process: remaining falls by elapsed time, floored at zero
  assign elapsed = cmd_i.timestamp - run_q.start;
  always_comb begin
    old_entry = run_q.ent;
    if ({16'd0, run_q.ent.remaining} > elapsed) begin
      old_entry.remaining = run_q.ent.remaining - elapsed[15:0];
    end else begin
      old_entry.remaining = '0;
    end
  end

  assign ins_entry  = do_preempt ? old_entry : new_entry;
  assign scan_entry = cell_q[scan_idx_q];

  // Insert position: first occupied cell with a larger priority number
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      gt[k] = (CW'(k) < count_q) && (cmd_i.new_priority < cell_q[k].prio);
    end
    ahead[0] = 1'b0;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      ahead[k] = ahead[k-1] | gt[k-1];
    end
    any_gt = ahead[QUEUE_DEPTH-1] | gt[QUEUE_DEPTH-1];
  end

  // Per-cell operation
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      cell_op[k] = CELL_HOLD;
      if (do_preempt) begin
        if (CW'(k) == count_q) begin
          cell_op[k] = CELL_LOAD;
        end
      end else if (do_insert) begin
        if ((gt[k] && !ahead[k]) || (!any_gt && (CW'(k) == count_q))) begin
          cell_op[k] = CELL_LOAD;
        end else if (ahead[k] && (CW'(k) <= count_q)) begin
          cell_op[k] = CELL_FROM_PREV;
        end
      end else if (apply) begin
        if ((CW'(k) >= CW'(best_idx_q)) && (CW'(k + 1) < count_q)) begin
          cell_op[k] = CELL_FROM_NEXT;
        end
      end
    end
  end

  // Sequencer, running register and result word
  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    ts_d        = ts_q;
    count_d     = count_q;
    run_valid_d = run_valid_q;
    run_d       = run_q;

    if (do_start) begin
      run_valid_d = 1'b1;
      run_d.ent   = new_entry;
      run_d.start = cmd_i.timestamp;
      run_d.fin   = cmd_i.timestamp + {16'd0, cmd_i.new_total_burst};
    end
    if (do_preempt || do_insert) begin
      count_d = count_q + CW'(1);
    end
    if (comp_empty) begin
      run_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (completion && !comp_empty) begin
          best_d     = cell_q[0];
          best_idx_d = '0;
          scan_idx_d = IW'(1);
          ts_d       = cmd_i.timestamp;
          state_d    = (count_q == CW'(1)) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_entry.prio < best_q.prio) begin
          best_d     = scan_entry;
          best_idx_d = scan_idx_q;
        end
        if (CW'(scan_idx_q) == count_q - CW'(1)) begin
          state_d = ST_APPLY;
        end else begin
          scan_idx_d = scan_idx_q + IW'(1);
        end
      end
      ST_APPLY: begin
        run_valid_d = 1'b1;
        run_d.ent   = best_q;
        run_d.start = ts_q;
        run_d.fin   = ts_q + {16'd0, best_q.remaining};
        count_d     = count_q - CW'(1);
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    done_d = arrival || comp_empty || apply;

    res_d           = '0;
    res_d.idle      = !run_valid_d;
    res_d.dropped   = do_drop;
    res_d.preempted = do_preempt;
    if (run_valid_d) begin
      res_d.run_id              = run_d.ent.pid;
      res_d.run_arrival         = run_d.ent.arrival;
      res_d.run_total_burst     = run_d.ent.total;
      res_d.run_remaining_burst = run_d.ent.remaining;
      res_d.run_priority        = run_d.ent.prio;
      res_d.run_start           = run_d.start;
      res_d.run_end             = run_d.fin;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      run_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      run_valid_q <= run_valid_d;
      done_q      <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    ts_q       <= ts_d;
    res_q      <= res_d;
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
